// ----- design/quadrature_decoder_speed_filter_unit_assert.svh -----
// Assertion macros used by the quadrature decoder speed filter back end.
`ifndef QUADRATURE_DECODER_SPEED_FILTER_UNIT_ASSERT_SVH
`define QUADRATURE_DECODER_SPEED_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QDSF_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("qdsf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define QDSF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("qdsf: next-cycle check failed");

`endif

// ----- design/qdsf_pkg.sv -----
// Shared types, constants and decode function for the quadrature decoder speed filter.
package qdsf_pkg;

	localparam int FRAC_BITS = 8;

	localparam int POS_W    = 32;
	localparam int STEP_W   = 2;
	localparam int TS_W     = 32;
	localparam int PER_W    = 20;
	localparam int RAW_W    = 32;
	localparam int FILT_W   = 40;
	localparam int WEIGHT_W = 9;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd51;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
	localparam int                  WEIGHT_SHIFT = 8;

	// microseconds per second
	localparam logic [PER_W-1:0] US_PER_S = 20'd1000000;

	// 360/2800 reduced
	localparam int SCALE_MUL = 9;
	localparam int SCALE_DIV = 70;

	// fixed-point widths of the filter path
	localparam int FRESH_W = RAW_W + FRAC_BITS;
	localparam int EXT_W   = (FRESH_W > FILT_W) ? FRESH_W : FILT_W;
	localparam int PROD_W  = FILT_W + WEIGHT_W + 1;
	localparam int X9_W    = FILT_W + 4;

	// shared divider: radix-16 restoring
	localparam int MUL_W     = RAW_W + PER_W;
	localparam int DIV_BITS  = 4;
	localparam int DIV_W     = ((MUL_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
	localparam int DIV_STEPS = DIV_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int DIVISOR_W = PER_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic signed [STEP_W-1:0] STEP_FWD  = 2'sb01;
	localparam logic signed [STEP_W-1:0] STEP_REV  = 2'sb11;
	localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;

	typedef enum logic {
		CMD_PIN   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// one classified word between front and back
	typedef struct packed {
		cmd_t                     cmd;
		logic [POS_W-1:0]         position;
		logic signed [STEP_W-1:0] step;
		logic [TS_W-1:0]          interval;
		logic [POS_W-1:0]         delta;
		logic [PER_W-1:0]         period;
	} rec_t;

	// divider request
	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	// x4 quadrature decode of previous and current {B,A}
	function automatic logic signed [STEP_W-1:0] transition(input logic [1:0] prev,
		input logic [1:0] cur);
		logic signed [STEP_W-1:0] s;
		unique case ({prev, cur}) inside
			4'b0001, 4'b0111, 4'b1110, 4'b1000: s = STEP_FWD;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_REV;
			default:                            s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

// ----- design/qdsf_front.sv -----
// Front end: accepts words, decodes quadrature pin samples and snapshots counts for queries.
module qdsf_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 full,
	input  logic                                 command,
	input  logic                                 pin_a,
	input  logic                                 pin_b,
	input  logic [qdsf_pkg::TS_W-1:0]            timestamp_us,
	input  logic [qdsf_pkg::PER_W-1:0]           period_us,
	output logic                                 enq,
	output qdsf_pkg::rec_t                       enq_data
);

	logic [1:0]                     prev_ab_q;
	logic [qdsf_pkg::POS_W-1:0]     tick_q;
	logic [qdsf_pkg::POS_W-1:0]     last_query_q;
	logic [qdsf_pkg::TS_W-1:0]      prev_ts_q;

	logic [1:0]                         cur_ab;
	logic signed [qdsf_pkg::STEP_W-1:0] step_val;
	logic [qdsf_pkg::POS_W-1:0]         tick_next;

	assign enq    = push && !full;
	assign cur_ab = {pin_b, pin_a};

	// decode the transition and the new count
	always_comb begin
		step_val = qdsf_pkg::transition(prev_ab_q, cur_ab);
		if (step_val == qdsf_pkg::STEP_FWD) begin
			tick_next = tick_q + qdsf_pkg::POS_W'(1);
		end else if (step_val == qdsf_pkg::STEP_REV) begin
			tick_next = tick_q - qdsf_pkg::POS_W'(1);
		end else begin
			tick_next = tick_q;
		end
	end

	// build the word for the back end
	always_comb begin
		enq_data.period = period_us;
		if (command == qdsf_pkg::CMD_QUERY) begin
			enq_data.cmd      = qdsf_pkg::CMD_QUERY;
			enq_data.position = tick_q;
			enq_data.step     = qdsf_pkg::STEP_NONE;
			enq_data.interval = '0;
			enq_data.delta    = tick_q - last_query_q;
		end else begin
			enq_data.cmd      = qdsf_pkg::CMD_PIN;
			enq_data.position = tick_next;
			enq_data.step     = step_val;
			enq_data.interval = timestamp_us - prev_ts_q;
			enq_data.delta    = '0;
		end
	end

	// advance decoder state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q    <= '0;
			tick_q       <= '0;
			last_query_q <= '0;
			prev_ts_q    <= '0;
		end else if (enq) begin
			if (command == qdsf_pkg::CMD_QUERY) begin
				last_query_q <= tick_q;
			end else begin
				prev_ab_q <= cur_ab;
				tick_q    <= tick_next;
				prev_ts_q <= timestamp_us;
			end
		end
	end

endmodule

// ----- design/qdsf_queue.sv -----
// Short register queue between the front end and the back end.
module qdsf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           enq,
	input  qdsf_pkg::rec_t enq_data,
	output logic           full,
	input  logic           deq,
	output qdsf_pkg::rec_t deq_data,
	output logic           empty
);

	qdsf_pkg::rec_t                mem_q [qdsf_pkg::QUEUE_DEPTH];
	logic [qdsf_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [qdsf_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [qdsf_pkg::QPTR_W:0]     count_q;

	assign full     = (count_q == (qdsf_pkg::QPTR_W + 1)'(qdsf_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign deq_data = mem_q[rd_ptr_q];

	// store the incoming word
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= enq_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				if (wr_ptr_q == qdsf_pkg::QPTR_W'(qdsf_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + qdsf_pkg::QPTR_W'(1);
				end
			end
			if (deq) begin
				if (rd_ptr_q == qdsf_pkg::QPTR_W'(qdsf_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + qdsf_pkg::QPTR_W'(1);
				end
			end
			if (enq && !deq) begin
				count_q <= count_q + (qdsf_pkg::QPTR_W + 1)'(1);
			end else if (deq && !enq) begin
				count_q <= count_q - (qdsf_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule

// ----- design/qdsf_div.sv -----
// Shared unsigned restoring divider, four quotient bits per cycle.
module qdsf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qdsf_pkg::div_req_t            req,
	output logic                          done,
	output logic [qdsf_pkg::DIV_W-1:0]    quotient
);

	logic [qdsf_pkg::DIV_W-1:0]     quo_q;
	logic [qdsf_pkg::DIVISOR_W-1:0] rem_q;
	logic [qdsf_pkg::DIVISOR_W-1:0] dvs_q;
	logic [qdsf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [qdsf_pkg::DIVISOR_W:0]   r_w;
	logic [qdsf_pkg::DIV_W-1:0]     q_w;

	assign done     = done_q;
	assign quotient = quo_q;

	// four shift-and-subtract steps
	always_comb begin
		r_w = {1'b0, rem_q};
		q_w = quo_q;
		for (int k = 0; k < qdsf_pkg::DIV_BITS; k++) begin
			r_w = {r_w[qdsf_pkg::DIVISOR_W-1:0], q_w[qdsf_pkg::DIV_W-1]};
			q_w = {q_w[qdsf_pkg::DIV_W-2:0], 1'b0};
			if (r_w >= {1'b0, dvs_q}) begin
				r_w    = r_w - {1'b0, dvs_q};
				q_w[0] = 1'b1;
			end
		end
	end

	// load on start, iterate while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + qdsf_pkg::DIV_CNT_W'(1);
				if (cnt_q == qdsf_pkg::DIV_CNT_W'(qdsf_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= q_w;
			rem_q <= r_w[qdsf_pkg::DIVISOR_W-1:0];
		end
	end

endmodule

// ----- design/qdsf_back.sv -----
// Back end: delivers pin results and runs speed, smoothing and scaling for queries.
`include "quadrature_decoder_speed_filter_unit_assert.svh"

module qdsf_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [qdsf_pkg::WEIGHT_W-1:0]        cfg_wdata,
	input  logic                                 q_empty,
	input  qdsf_pkg::rec_t                       q_data,
	output logic                                 deq,
	input  logic                                 pop,
	output logic                                 out_valid,
	output logic [qdsf_pkg::POS_W-1:0]           out_position,
	output logic signed [qdsf_pkg::STEP_W-1:0]   out_step,
	output logic [qdsf_pkg::TS_W-1:0]            out_interval,
	output logic signed [qdsf_pkg::FILT_W-1:0]   out_speed
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_RAW,
		ST_EMA_NEW,
		ST_EMA_OLD,
		ST_EMA_SUM,
		ST_SCALE_GO,
		ST_DIV_SCALE
	} state_t;

	localparam logic signed [qdsf_pkg::RAW_W-1:0] RAW_MAX = {1'b0, {(qdsf_pkg::RAW_W-1){1'b1}}};
	localparam logic signed [qdsf_pkg::RAW_W-1:0] RAW_MIN = {1'b1, {(qdsf_pkg::RAW_W-1){1'b0}}};
	localparam logic signed [qdsf_pkg::FILT_W-1:0] FILT_MAX =
		{1'b0, {(qdsf_pkg::FILT_W-1){1'b1}}};
	localparam logic signed [qdsf_pkg::FILT_W-1:0] FILT_MIN =
		{1'b1, {(qdsf_pkg::FILT_W-1){1'b0}}};
	localparam logic [qdsf_pkg::DIV_W-1:0] RAW_MAX_MAG = qdsf_pkg::DIV_W'(RAW_MAX);
	localparam logic [qdsf_pkg::DIV_W-1:0] RAW_MIN_MAG =
		qdsf_pkg::DIV_W'({1'b1, {(qdsf_pkg::RAW_W-1){1'b0}}});

	state_t                                   state_q;
	logic [qdsf_pkg::WEIGHT_W-1:0]            weight_q;
	logic [qdsf_pkg::POS_W-1:0]               pos_q;
	logic                                     neg_q;
	logic [qdsf_pkg::RAW_W-1:0]               mag_q;
	logic [qdsf_pkg::PER_W-1:0]               per_q;
	logic signed [qdsf_pkg::RAW_W-1:0]        raw_q;
	logic signed [qdsf_pkg::PROD_W-1:0]       prod_new_q;
	logic signed [qdsf_pkg::PROD_W-1:0]       prod_old_q;
	logic signed [qdsf_pkg::FILT_W-1:0]       filt_q;
	logic signed [qdsf_pkg::FILT_W-1:0]       held_q;
	qdsf_pkg::div_req_t                       div_req_q;
	logic                                     out_valid_q;
	logic [qdsf_pkg::POS_W-1:0]               out_position_q;
	logic signed [qdsf_pkg::STEP_W-1:0]       out_step_q;
	logic [qdsf_pkg::TS_W-1:0]                out_interval_q;
	logic signed [qdsf_pkg::FILT_W-1:0]       out_speed_q;
	// marks that the scaled value of the current query is ready
	logic                                     deliver_q;

	logic                                     div_done;
	logic [qdsf_pkg::DIV_W-1:0]               div_quo;
	logic                                     out_free;
	logic                                     out_load;
	logic [qdsf_pkg::WEIGHT_W-1:0]            w_eff;
	logic [qdsf_pkg::WEIGHT_W-1:0]            w_old;
	logic [qdsf_pkg::MUL_W-1:0]               mul_prod;
	logic signed [qdsf_pkg::RAW_W-1:0]        raw_sat;
	logic signed [qdsf_pkg::EXT_W-1:0]        fresh_ext;
	logic signed [qdsf_pkg::FILT_W-1:0]       fresh;
	logic signed [qdsf_pkg::PROD_W:0]         ema_sum;
	logic signed [qdsf_pkg::PROD_W:0]         ema_shr;
	logic signed [qdsf_pkg::FILT_W-1:0]       filt_next;
	logic signed [qdsf_pkg::X9_W-1:0]         x9;
	logic [qdsf_pkg::X9_W-1:0]                x9_mag;
	logic signed [qdsf_pkg::FILT_W-1:0]       scaled;

	qdsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free     = !out_valid_q || pop;
	assign out_valid    = out_valid_q;
	assign out_position = out_position_q;
	assign out_step     = out_step_q;
	assign out_interval = out_interval_q;
	assign out_speed    = out_speed_q;

	// when idle, take a pin word only if the output is free, and any query word
	assign deq = (state_q == ST_IDLE) && !q_empty &&
		((q_data.cmd == qdsf_pkg::CMD_QUERY) || out_free);

	// load the output register with a pin result or a finished query
	assign out_load = (deq && (q_data.cmd == qdsf_pkg::CMD_PIN)) ||
		((state_q == ST_DIV_SCALE) && !div_done && deliver_q && out_free);

	// clamp the weight to one
	assign w_eff = (weight_q > qdsf_pkg::WEIGHT_ONE) ? qdsf_pkg::WEIGHT_ONE : weight_q;
	assign w_old = qdsf_pkg::WEIGHT_ONE - w_eff;

	// ticks times microseconds per second
	assign mul_prod = mag_q * qdsf_pkg::US_PER_S;

	// saturate the signed speed quotient to 32 bits
	always_comb begin
		if (!neg_q) begin
			raw_sat = (div_quo > RAW_MAX_MAG) ? RAW_MAX : signed'(div_quo[qdsf_pkg::RAW_W-1:0]);
		end else if (div_quo > RAW_MIN_MAG) begin
			raw_sat = RAW_MIN;
		end else begin
			raw_sat = -signed'(div_quo[qdsf_pkg::RAW_W-1:0]);
		end
	end

	// new sample in fixed point, clamped to the filter width
	always_comb begin
		fresh_ext = qdsf_pkg::EXT_W'(raw_q) <<< qdsf_pkg::FRAC_BITS;
		if (fresh_ext > qdsf_pkg::EXT_W'(FILT_MAX)) begin
			fresh = FILT_MAX;
		end else if (fresh_ext < qdsf_pkg::EXT_W'(FILT_MIN)) begin
			fresh = FILT_MIN;
		end else begin
			fresh = qdsf_pkg::FILT_W'(fresh_ext);
		end
	end

	// weighted sum, floor divide by the weight scale, clamp
	always_comb begin
		ema_sum = (qdsf_pkg::PROD_W + 1)'(prod_new_q) + (qdsf_pkg::PROD_W + 1)'(prod_old_q);
		ema_shr = ema_sum >>> qdsf_pkg::WEIGHT_SHIFT;
		if (ema_shr > (qdsf_pkg::PROD_W + 1)'(FILT_MAX)) begin
			filt_next = FILT_MAX;
		end else if (ema_shr < (qdsf_pkg::PROD_W + 1)'(FILT_MIN)) begin
			filt_next = FILT_MIN;
		end else begin
			filt_next = qdsf_pkg::FILT_W'(ema_shr);
		end
	end

	// numerator of the angle scaling and its magnitude
	always_comb begin
		x9     = qdsf_pkg::X9_W'(filt_q) * qdsf_pkg::X9_W'(qdsf_pkg::SCALE_MUL);
		x9_mag = x9[qdsf_pkg::X9_W-1] ? unsigned'(-x9) : unsigned'(x9);
	end

	// truncate the scaled quotient toward zero
	assign scaled = neg_q ? -signed'(div_quo[qdsf_pkg::FILT_W-1:0])
		: signed'(div_quo[qdsf_pkg::FILT_W-1:0]);

	// sequence one query, deliver results in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			weight_q        <= qdsf_pkg::WEIGHT_RESET;
			filt_q          <= '0;
			held_q          <= '0;
			out_valid_q     <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			div_req_q.start <= (state_q == ST_MUL) || (state_q == ST_SCALE_GO);
			if (cfg_we) begin
				weight_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (deq) begin
						if (q_data.cmd == qdsf_pkg::CMD_PIN) begin
							out_position_q <= q_data.position;
							out_step_q     <= q_data.step;
							out_interval_q <= q_data.interval;
							out_speed_q    <= held_q;
						end else begin
							pos_q <= q_data.position;
							neg_q <= q_data.delta[qdsf_pkg::POS_W-1];
							mag_q <= q_data.delta[qdsf_pkg::POS_W-1]
								? (-q_data.delta) : q_data.delta;
							per_q <= q_data.period;
							if (q_data.period == '0) begin
								// zero period: saturate in the sign of the count change
								if (q_data.delta == '0) begin
									raw_q <= '0;
								end else if (q_data.delta[qdsf_pkg::POS_W-1]) begin
									raw_q <= RAW_MIN;
								end else begin
									raw_q <= RAW_MAX;
								end
								state_q <= ST_EMA_NEW;
							end else begin
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_MUL: begin
					div_req_q.dividend <= qdsf_pkg::DIV_W'(mul_prod);
					div_req_q.divisor  <= per_q;
					state_q            <= ST_DIV_RAW;
				end
				ST_DIV_RAW: begin
					if (div_done) begin
						raw_q   <= raw_sat;
						state_q <= ST_EMA_NEW;
					end
				end
				ST_EMA_NEW: begin
					prod_new_q <= $signed({1'b0, w_eff}) * fresh;
					state_q    <= ST_EMA_OLD;
				end
				ST_EMA_OLD: begin
					prod_old_q <= $signed({1'b0, w_old}) * filt_q;
					state_q    <= ST_EMA_SUM;
				end
				ST_EMA_SUM: begin
					filt_q  <= filt_next;
					state_q <= ST_SCALE_GO;
				end
				ST_SCALE_GO: begin
					neg_q              <= x9[qdsf_pkg::X9_W-1];
					div_req_q.dividend <= qdsf_pkg::DIV_W'(x9_mag);
					div_req_q.divisor  <= qdsf_pkg::DIVISOR_W'(qdsf_pkg::SCALE_DIV);
					state_q            <= ST_DIV_SCALE;
				end
				ST_DIV_SCALE: begin
					// hold the query result until the output register frees
					if (div_done) begin
						held_q <= scaled;
					end else if (deliver_q && out_free) begin
						out_position_q <= pos_q;
						out_step_q     <= qdsf_pkg::STEP_NONE;
						out_interval_q <= '0;
						out_speed_q    <= held_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// mark the scaled value ready once the second division ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_q <= 1'b0;
		end else if (state_q != ST_DIV_SCALE) begin
			deliver_q <= 1'b0;
		end else if (div_done) begin
			deliver_q <= 1'b1;
		end
	end

	`QDSF_ASSERT_IMPLY(a_deq_nonempty, clk, arst_n, deq, !q_empty)
	`QDSF_ASSERT_IMPLY(a_done_in_wait, clk, arst_n, div_done,
		(state_q == ST_DIV_RAW) || (state_q == ST_DIV_SCALE))
	`QDSF_ASSERT_NEXT(a_hold_result, clk, arst_n, out_valid_q && !pop,
		out_valid_q && $stable(out_position_q) && $stable(out_speed_q))

endmodule

// ----- design/quadrature_decoder_speed_filter_unit.sv -----
// Pin samples: a sample is taken only when the output is free, and its result shows in the next cycle.
// Speed queries run the multiply, the speed division, the filter update and the scaling division
//   in order, skipping the first two at zero period; the divider gives four quotient bits a cycle.
// Pin samples go one per cycle while results are popped; the back end takes no word during a query.
// A two-word queue lets new words enter while the back end works or a result waits.
// Reset: arst_n clears position, timestamps and filter state at once; weight resets to 51.
module quadrature_decoder_speed_filter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [qdsf_pkg::WEIGHT_W-1:0]        cfg_wdata,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 command,
	input  logic                                 pin_a,
	input  logic                                 pin_b,
	input  logic [qdsf_pkg::TS_W-1:0]            timestamp_us,
	input  logic [qdsf_pkg::PER_W-1:0]           period_us,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [qdsf_pkg::POS_W-1:0]    position,
	output logic signed [qdsf_pkg::STEP_W-1:0]   step,
	output logic [qdsf_pkg::TS_W-1:0]            edge_interval_us,
	output logic signed [qdsf_pkg::FILT_W-1:0]   scaled_speed
);

	logic                          enq;
	qdsf_pkg::rec_t                enq_data;
	logic                          deq;
	qdsf_pkg::rec_t                deq_data;
	logic                          q_empty;
	logic                          out_valid;
	logic [qdsf_pkg::POS_W-1:0]    out_position;

	qdsf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.pin_a        (pin_a),
		.pin_b        (pin_b),
		.timestamp_us (timestamp_us),
		.period_us    (period_us),
		.enq          (enq),
		.enq_data     (enq_data)
	);

	qdsf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_data (enq_data),
		.full     (full),
		.deq      (deq),
		.deq_data (deq_data),
		.empty    (q_empty)
	);

	qdsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_empty      (q_empty),
		.q_data       (deq_data),
		.deq          (deq),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_position (out_position),
		.out_step     (step),
		.out_interval (edge_interval_us),
		.out_speed    (scaled_speed)
	);

	assign empty    = !out_valid;
	assign position = signed'(out_position);

endmodule
